// ===== src/crcs_pkg.sv =====
// ----------------------------------------------------------------------------
// crcs_pkg: shared types and constants for the serial CRC generator/checker
// Sizes, register map, command codes and degree helpers used by every stage.
// ----------------------------------------------------------------------------
package crcs_pkg;

  localparam int MAX_DEGREE  = 32;
  localparam int REM_W       = MAX_DEGREE;
  localparam int CNT_W       = $clog2(MAX_DEGREE + 1);
  localparam int GEN_W       = 32;
  localparam int DEG_W       = 6;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REG_GEN  = 2'd0;
  localparam logic [1:0] REG_DEG  = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  localparam logic [GEN_W-1:0] GEN_RESET = 32'h04C1_1DB7;
  localparam logic [DEG_W-1:0] DEG_RESET = 6'd32;

  localparam logic [1:0] CMD_ECHO     = 2'd0;
  localparam logic [1:0] CMD_ECHO_CRC = 2'd1;
  localparam logic [1:0] CMD_CHECK    = 2'd2;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [DEG_W-1:0] degree;
    logic             check_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             data;
    logic             err;
    logic [REM_W-1:0] rem;
    logic [CNT_W-1:0] degree;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_sts_t;

  // Degree 0 behaves as 1, anything above MAX_DEGREE as MAX_DEGREE.
  function automatic logic [CNT_W-1:0] eff_degree(input logic [DEG_W-1:0] deg);
    logic [CNT_W-1:0] d;
    if (deg == '0) begin
      d = CNT_W'(1);
    end else if (32'(deg) > MAX_DEGREE) begin
      d = CNT_W'(MAX_DEGREE);
    end else begin
      d = CNT_W'(deg);
    end
    return d;
  endfunction

  function automatic logic [REM_W-1:0] deg_mask(input logic [CNT_W-1:0] d);
    logic [REM_W-1:0] m;
    for (int i = 0; i < REM_W; i++) begin
      m[i] = (i < int'(d));
    end
    return m;
  endfunction

endpackage

// ===== src/crcs_if.sv =====
// ----------------------------------------------------------------------------
// crcs_if: valid/ready channels of the serial CRC unit
// One interface for incoming bits and one for result beats.
// ----------------------------------------------------------------------------
interface crcs_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic final_bit;

  modport source(output valid, output data_bit, output final_bit, input ready);
  modport sink(input valid, input data_bit, input final_bit, output ready);
endinterface

interface crcs_out_if;
  logic valid;
  logic ready;
  logic out_bit;
  logic is_check_bit;
  logic error_flag;
  logic run_last;

  modport source(output valid, output out_bit, output is_check_bit,
                 output error_flag, output run_last, input ready);
  modport sink(input valid, input out_bit, input is_check_bit,
               input error_flag, input run_last, output ready);
endinterface

// ===== src/crcs_front.sv =====
// ----------------------------------------------------------------------------
// crcs_front: bit intake and remainder update
// Accepts one bit per beat, steps the polynomial division and queues a
// command for each beat that produces results.
// ----------------------------------------------------------------------------
module crcs_front import crcs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  crcs_in_if.sink       in_bus,
  input  logic          q_space,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] rem_step, mask, gen, top_vec;
  logic [CNT_W-1:0] deg;
  logic             top, fb, accept;

  assign in_bus.ready = q_space;
  assign accept       = in_bus.valid & in_bus.ready;

  always_comb begin
    deg     = eff_degree(cfg.degree);
    mask    = deg_mask(deg);
    gen     = REM_W'(cfg.gen) & mask;
    top_vec = rem_r >> (deg - CNT_W'(1));
    top     = top_vec[0];
    fb      = in_bus.data_bit ^ top;
    if (cfg.check_mode) begin
      // Plain long division: the codeword bit enters at the bottom.
      rem_step = (((rem_r << 1) | REM_W'(in_bus.data_bit)) & mask) ^ (top ? gen : '0);
    end else begin
      // Division of message * x^degree: the bit feeds back at the top.
      rem_step = ((rem_r << 1) & mask) ^ (fb ? gen : '0);
    end
  end

  always_comb begin
    q_push = accept & (~cfg.check_mode | in_bus.final_bit);
    if (cfg.check_mode) begin
      q_cmd.kind = CMD_CHECK;
    end else if (in_bus.final_bit) begin
      q_cmd.kind = CMD_ECHO_CRC;
    end else begin
      q_cmd.kind = CMD_ECHO;
    end
    q_cmd.data   = in_bus.data_bit;
    q_cmd.err    = |rem_step;
    q_cmd.rem    = rem_step;
    q_cmd.degree = deg;
  end

  always_comb begin
    rem_nxt = rem_r;
    if (accept) begin
      rem_nxt = in_bus.final_bit ? '0 : rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== src/crcs_queue.sv =====
// ----------------------------------------------------------------------------
// crcs_queue: command queue between intake and output
// Small register FIFO; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module crcs_queue import crcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic space,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign space      = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // Pointers wrap at the end of the array.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/crcs_back.sv =====
// ----------------------------------------------------------------------------
// crcs_back: result sequencer
// Turns queued commands into result beats and shifts out check bits,
// most significant first, one per beat.
// ----------------------------------------------------------------------------
module crcs_back import crcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head,
  output back_sts_t sts,
  crcs_out_if.source out_bus
);

  logic             out_valid_r, out_valid_nxt;
  logic             out_bit_r, out_bit_nxt;
  logic             chk_r, chk_nxt;
  logic             err_r, err_nxt;
  logic             last_r, last_nxt;
  logic [REM_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             load, pop;

  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_bit      = out_bit_r;
  assign out_bus.is_check_bit = chk_r;
  assign out_bus.error_flag   = err_r;
  assign out_bus.run_last     = last_r;

  assign load     = ~out_valid_r | out_bus.ready;
  assign sts.busy = (cnt_r != '0);
  assign sts.pop  = pop;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    chk_nxt       = chk_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    pop           = 1'b0;
    if (load) begin
      if (cnt_r != '0) begin
        out_valid_nxt = 1'b1;
        out_bit_nxt   = sh_r[REM_W-1];
        chk_nxt       = 1'b1;
        err_nxt       = 1'b0;
        last_nxt      = (cnt_r == CNT_W'(1));
        sh_nxt        = sh_r << 1;
        cnt_nxt       = cnt_r - CNT_W'(1);
      end else if (head_valid) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        chk_nxt       = 1'b0;
        unique case (head.kind)
          CMD_CHECK: begin
            out_bit_nxt = 1'b0;
            err_nxt     = head.err;
            last_nxt    = 1'b1;
          end
          CMD_ECHO_CRC: begin
            out_bit_nxt = head.data;
            err_nxt     = 1'b0;
            last_nxt    = 1'b0;
            // Left-justify the remainder so the top check bit sits at the MSB.
            sh_nxt      = head.rem << (CNT_W'(REM_W) - head.degree);
            cnt_nxt     = head.degree;
          end
          default: begin
            out_bit_nxt = head.data;
            err_nxt     = 1'b0;
            last_nxt    = 1'b1;
          end
        endcase
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_bit_r <= out_bit_nxt;
    chk_r     <= chk_nxt;
    err_r     <= err_nxt;
    last_r    <= last_nxt;
    sh_r      <= sh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

// ===== src/crc_generate_check_serial_unit.sv =====
// ----------------------------------------------------------------------------
// crc_generate_check_serial_unit: bit-serial CRC generator and checker
// Programmable generator polynomial with implied leading one. Generate mode
// echoes each bit and appends the check bits; check mode flags a non-zero
// remainder on the last codeword bit.
//
//   channel   | kind        | beat content
//   ----------+-------------+-------------------------------------------------
//   in_bus    | valid/ready | data_bit, final_bit
//   out_bus   | valid/ready | out_bit, is_check_bit, error_flag, run_last
//   APB       | psel/penable| generator_low_bits @0, crc_degree @4, check_mode @8
//
// Input bits are taken one per cycle while the queue has space; the remainder
// update is a single shift and XOR. Output beats leave one per cycle from the
// output register when out_bus.ready allows. A final bit in generate mode costs
// degree+1 output beats, so input stalls once the two-entry command queue fills.
// Reset (rst_n low, synchronous) clears the remainder, queue and output, and
// loads the default CRC-32 generator, degree 32 and generate mode.
// ----------------------------------------------------------------------------
module crc_generate_check_serial_unit import crcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  crcs_in_if.sink           in_bus,
  crcs_out_if.source        out_bus
);

  logic [GEN_W-1:0] gen_r, gen_nxt;
  logic [DEG_W-1:0] deg_r, deg_nxt;
  logic             mode_r, mode_nxt;
  logic             wr_en;
  cfg_t             cfg;

  logic      q_push, q_space, q_valid;
  cmd_t      q_cmd, q_head;
  back_sts_t back_sts;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    gen_nxt  = gen_r;
    deg_nxt  = deg_r;
    mode_nxt = mode_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_GEN:  gen_nxt  = pwdata[GEN_W-1:0];
        REG_DEG:  deg_nxt  = pwdata[DEG_W-1:0];
        REG_MODE: mode_nxt = pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GEN:  prdata = DATA_W'(gen_r);
      REG_DEG:  prdata = DATA_W'(deg_r);
      REG_MODE: prdata = DATA_W'(mode_r);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= GEN_RESET;
      deg_r  <= DEG_RESET;
      mode_r <= 1'b0;
    end else begin
      gen_r  <= gen_nxt;
      deg_r  <= deg_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign cfg.gen        = gen_r;
  assign cfg.degree     = deg_r;
  assign cfg.check_mode = mode_r;

  crcs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .q_space (q_space),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  crcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .space      (q_space),
    .pop        (back_sts.pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  crcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .sts        (back_sts),
    .out_bus    (out_bus)
  );

  // The sequencer only takes a command that is actually queued.
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    back_sts.pop |-> q_valid)
    else $error("queue popped while empty");

  // No new command is taken while check bits are still being shifted out.
  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    back_sts.busy |-> !back_sts.pop)
    else $error("command popped during check-bit run");

  // An error flag only ever comes on a closing check-mode beat.
  a_err_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.error_flag) |-> (!out_bus.is_check_bit && out_bus.run_last))
    else $error("error flag on a non-check-result beat");

endmodule
